FILE: rtl/core/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dirty rectangle refresh block
// Holds coordinate and ring geometry, request codes, register indexes and
// the structs passed between the damage tracker and the ring writer.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Width of the coordinate fields on the request channel.
    localparam int IN_COORD_W = 16;
    // Width of the stored damage coordinates.
    localparam int COORD_BITS = 16;
    localparam int CMAX = (2 ** (COORD_BITS - 1)) - 1;
    localparam int CMIN = -(2 ** (COORD_BITS - 1));

    // Ring byte offsets.
    localparam int POS_W = 19;
    localparam logic [31:0] RING_BYTES = 32'd262144;

    localparam int WORD_W = 32;
    localparam int INDEX_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_CLEAR   = 2'd1,
        FUNC_REFRESH = 2'd2,
        FUNC_INIT    = 2'd3
    } drt_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_START    = 2'd0,
        CFG_RING_END      = 2'd1,
        CFG_UPDATE_OPCODE = 2'd2
    } drt_cfg_idx_t;

    // Position of a word within one update command.
    typedef enum logic [2:0] {
        WORD_OPCODE = 3'd0,
        WORD_LEFT   = 3'd1,
        WORD_TOP    = 3'd2,
        WORD_WIDTH  = 3'd3,
        WORD_HEIGHT = 3'd4
    } drt_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  ring_start;
        logic [POS_W-1:0]  ring_end;
        logic [WORD_W-1:0] update_opcode;
    } drt_cfg_t;

    // Update command handed from the damage tracker to the ring writer.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
    } drt_cmd_t;

    // Clamp an incoming corner to the stored coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [IN_COORD_W-1:0] v
    );
        int x;
        x = int'(v);
        if (x > CMAX) begin
            x = CMAX;
        end
        if (x < CMIN) begin
            x = CMIN;
        end
        return COORD_BITS'(x);
    endfunction

endpackage

FILE: rtl/core/drt_req_if.sv
// ----------------------------------------------------------------------------
// drt_req_if: request channel of the dirty rectangle refresh block
// Valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface drt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;
    logic        device_busy;
    logic [18:0] consumer_stop;

    modport source (
        output valid, func, box_left, box_top, box_right, box_bottom,
               device_busy, consumer_stop,
        input  ready
    );
    modport sink (
        input  valid, func, box_left, box_top, box_right, box_bottom,
               device_busy, consumer_stop,
        output ready
    );
endinterface

FILE: rtl/core/drt_res_if.sv
// ----------------------------------------------------------------------------
// drt_res_if: ring word channel of the dirty rectangle refresh block
// Valid/ready handshake carrying one command ring write.
// ----------------------------------------------------------------------------
interface drt_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_index;
    logic [31:0] word_data;
    logic        sync_before;
    logic        sync_after;
    logic        last_word;

    modport source (
        output valid, word_index, word_data, sync_before, sync_after, last_word,
        input  ready
    );
    modport sink (
        input  valid, word_index, word_data, sync_before, sync_after, last_word,
        output ready
    );
endinterface

FILE: rtl/core/drt_box.sv
// ----------------------------------------------------------------------------
// drt_box: damage bounding box tracker
// Keeps the union box of damaged rectangles and builds the update command
// when a refresh request finds a box worth drawing.
// ----------------------------------------------------------------------------
module drt_box
    import drt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  drt_func_t             func,
    input  logic [IN_COORD_W-1:0] box_left,
    input  logic [IN_COORD_W-1:0] box_top,
    input  logic [IN_COORD_W-1:0] box_right,
    input  logic [IN_COORD_W-1:0] box_bottom,
    input  logic                  device_busy,
    output drt_cmd_t              cmd
);

    logic signed [COORD_BITS-1:0] left_reg, left_next;
    logic signed [COORD_BITS-1:0] top_reg, top_next;
    logic signed [COORD_BITS-1:0] right_reg, right_next;
    logic signed [COORD_BITS-1:0] bottom_reg, bottom_next;

    logic signed [COORD_BITS-1:0] x_a, x_b, y_a, y_b;
    logic signed [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [32:0]           left_x, top_x, right_x, bottom_x;
    logic                         drawable;

    always_comb
    begin
        x_a  = sat_coord($signed(box_left));
        y_a  = sat_coord($signed(box_top));
        x_b  = sat_coord($signed(box_right));
        y_b  = sat_coord($signed(box_bottom));
        x_lo = (x_a > x_b) ? x_b : x_a;
        x_hi = (x_a > x_b) ? x_a : x_b;
        y_lo = (y_a > y_b) ? y_b : y_a;
        y_hi = (y_a > y_b) ? y_a : y_b;

        left_x   = 33'(left_reg);
        top_x    = 33'(top_reg);
        right_x  = 33'(right_reg);
        bottom_x = 33'(bottom_reg);

        drawable = (right_reg > left_reg) && (bottom_reg > top_reg);

        cmd.start  = take && (func == FUNC_REFRESH) && !device_busy && drawable;
        cmd.left   = 32'(left_x);
        cmd.top    = 32'(top_x);
        cmd.width  = 32'(right_x - left_x + 33'sd1);
        cmd.height = 32'(bottom_x - top_x + 33'sd1);

        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        if (take && func == FUNC_ADD) begin
            if (x_lo < left_reg) begin
                left_next = x_lo;
            end
            if (y_lo < top_reg) begin
                top_next = y_lo;
            end
            if (x_hi > right_reg) begin
                right_next = x_hi;
            end
            if (y_hi > bottom_reg) begin
                bottom_next = y_hi;
            end
        end
        if ((take && func == FUNC_CLEAR) || cmd.start) begin
            left_next   = COORD_BITS'(CMAX);
            top_next    = COORD_BITS'(CMAX);
            right_next  = COORD_BITS'(CMIN);
            bottom_next = COORD_BITS'(CMIN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_reg   <= COORD_BITS'(CMAX);
            top_reg    <= COORD_BITS'(CMAX);
            right_reg  <= COORD_BITS'(CMIN);
            bottom_reg <= COORD_BITS'(CMIN);
        end else begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

    // A refresh that goes out always leaves the empty box behind.
    a_clear_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (left_reg == COORD_BITS'(CMAX)) && (right_reg == COORD_BITS'(CMIN)))
        else $error("damage box not cleared after refresh");

    // The box only grows on an add request.
    a_grow_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && func == FUNC_ADD) |=> !($past(right_reg) < right_reg))
        else $error("damage box grew without an add request");

    // Nothing is sent while the device is busy.
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        device_busy |-> !cmd.start)
        else $error("refresh started while device busy");

endmodule

FILE: rtl/core/drt_ring.sv
// ----------------------------------------------------------------------------
// drt_ring: command ring writer
// Sends the five words of an update command one per cycle, unless res stalls,
// to an output register, tracks the ring write position, flags a full ring.
// ----------------------------------------------------------------------------
module drt_ring
    import drt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  drt_cfg_t         cfg,
    input  drt_cmd_t         cmd,
    input  logic [POS_W-1:0] stop,
    input  logic             init,
    output logic             busy,
    drt_res_if.source        res
);

    logic              active_reg, active_next;
    drt_word_t         word_reg, word_next;
    drt_cmd_t          cmd_reg;
    logic [POS_W-1:0]  stop_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic              out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic              out_sync_before_reg;
    logic              out_last_reg;

    logic              emit;
    logic              final_word;
    logic [WORD_W-1:0] data;
    logic [POS_W:0]    pos_plus;
    logic [POS_W:0]    end_minus;
    logic              full;

    assign busy = active_reg;
    assign emit = active_reg && (!out_valid_reg || res.ready);

    always_comb
    begin
        pos_plus  = {1'b0, pos_reg} + (POS_W + 1)'(4);
        end_minus = {1'b0, cfg.ring_end} - (POS_W + 1)'(4);
        full = (pos_plus == {1'b0, stop_reg}) ||
               (({1'b0, pos_reg} == end_minus) && (stop_reg == cfg.ring_start));

        final_word = 1'b0;
        case (word_reg)
            WORD_OPCODE:
            begin
                data      = cfg.update_opcode;
                word_next = WORD_LEFT;
            end
            WORD_LEFT:
            begin
                data      = cmd_reg.left;
                word_next = WORD_TOP;
            end
            WORD_TOP:
            begin
                data      = cmd_reg.top;
                word_next = WORD_WIDTH;
            end
            WORD_WIDTH:
            begin
                data      = cmd_reg.width;
                word_next = WORD_HEIGHT;
            end
            WORD_HEIGHT:
            begin
                data       = cmd_reg.height;
                word_next  = WORD_OPCODE;
                final_word = 1'b1;
            end
            default:
            begin
                data      = cfg.update_opcode;
                word_next = WORD_OPCODE;
            end
        endcase

        active_next = active_reg;
        pos_next    = pos_reg;
        if (cmd.start) begin
            active_next = 1'b1;
            word_next   = WORD_OPCODE;
        end else if (emit) begin
            active_next = !final_word;
            if (pos_plus == {1'b0, cfg.ring_end} || 32'(pos_plus) >= RING_BYTES) begin
                pos_next = cfg.ring_start;
            end else begin
                pos_next = pos_plus[POS_W-1:0];
            end
        end else begin
            word_next = word_reg;
        end
        if (init) begin
            pos_next = cfg.ring_start;
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (res.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            word_reg      <= WORD_OPCODE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            word_reg      <= word_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start) begin
            cmd_reg  <= cmd;
            stop_reg <= stop;
        end
        if (emit) begin
            out_index_reg       <= pos_reg[INDEX_W+1:2];
            out_data_reg        <= data;
            out_sync_before_reg <= full;
            out_last_reg        <= final_word;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.word_index  = out_index_reg;
    assign res.word_data   = out_data_reg;
    assign res.sync_before = out_sync_before_reg;
    assign res.sync_after  = out_last_reg;
    assign res.last_word   = out_last_reg;

    // A new command or ring init never lands on a command in flight.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start || init) |-> !active_reg)
        else $error("ring writer restarted while busy");

    // A started command begins with its opcode word.
    a_start_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> active_reg && (word_reg == WORD_OPCODE))
        else $error("command did not begin with opcode");

    // Sending the height word ends the command.
    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && final_word) |=> !active_reg && out_valid_reg && out_last_reg)
        else $error("command did not end after the fifth word");

endmodule

FILE: rtl/core/dirty_rect_refresh_cmd_ring_top.sv
// ----------------------------------------------------------------------------
// dirty_rect_refresh_cmd_ring_top: dirty rectangle tracker with command ring
// Merges damaged rectangles into one bounding box and, on a refresh
// request, writes a five-word update command into the command ring.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake       Content
//  req      in         valid / ready   func, box corners, busy, consumer stop
//  res      out        valid / ready   one ring word with index and sync flags
//  cfg      in         cfg_we only     ring_start, ring_end, update_opcode
//
// A request is registered when it is accepted and is carried out once the
// ring writer is free, so add, clear and ring init requests go through at
// one per cycle while the ring writer is idle. A refresh that sends a command
// occupies the ring writer while it loads the command and sends it, one ring
// word per cycle unless res stalls; the request stage holds the next request.
// The result register parts the two sides: a stalled res channel only stops
// the ring writer, and the request register keeps accepting until it is
// itself blocked. Reset empties the box, sets the write position to zero and
// loads the register defaults; there is no clearing pass.
//
module dirty_rect_refresh_cmd_ring_top
    import drt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    drt_req_if.sink              req,
    drt_res_if.source            res
);

    // Configuration registers.
    drt_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.ring_start    <= POS_W'(1024);
            cfg_reg.ring_end      <= POS_W'(262144);
            cfg_reg.update_opcode <= WORD_W'(1);
        end else if (cfg_we) begin
            case (drt_cfg_idx_t'(cfg_index))
                CFG_RING_START:    cfg_reg.ring_start    <= cfg_data[POS_W-1:0];
                CFG_RING_END:      cfg_reg.ring_end      <= cfg_data[POS_W-1:0];
                CFG_UPDATE_OPCODE: cfg_reg.update_opcode <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Request register. The held request is carried out once the ring
    // writer is free, which keeps ring init and a new refresh behind any
    // command still being sent.
    logic                  req_valid_reg;
    drt_func_t             func_reg;
    logic [IN_COORD_W-1:0] left_reg;
    logic [IN_COORD_W-1:0] top_reg;
    logic [IN_COORD_W-1:0] right_reg;
    logic [IN_COORD_W-1:0] bottom_reg;
    logic                  busy_reg;
    logic [POS_W-1:0]      stop_reg;

    logic                  ring_busy;
    logic                  take;
    drt_cmd_t              cmd;

    assign take      = req_valid_reg && !ring_busy;
    assign req.ready = !req_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end else if (req.ready) begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            func_reg   <= drt_func_t'(req.func);
            left_reg   <= req.box_left;
            top_reg    <= req.box_top;
            right_reg  <= req.box_right;
            bottom_reg <= req.box_bottom;
            busy_reg   <= req.device_busy;
            stop_reg   <= req.consumer_stop;
        end
    end

    drt_box u_box (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .func        (func_reg),
        .box_left    (left_reg),
        .box_top     (top_reg),
        .box_right   (right_reg),
        .box_bottom  (bottom_reg),
        .device_busy (busy_reg),
        .cmd         (cmd)
    );

    drt_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cmd   (cmd),
        .stop  (stop_reg),
        .init  (take && func_reg == FUNC_INIT),
        .busy  (ring_busy),
        .res   (res)
    );

    // A held request waits only while a command is being sent.
    a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && ring_busy) |=> req_valid_reg && $stable(func_reg))
        else $error("request left the register while the ring was busy");

    // A request is never dropped: if it is not taken, the register stays full.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !take) |-> !req.ready)
        else $error("request register accepted over a pending request");

    // A refresh that sends a command makes the ring writer busy next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> ring_busy && !take)
        else $error("ring writer not busy after a refresh");

endmodule
